[src/bpm_pkg.sv]
// Shared types, codes and frame helpers of the bus poll master.
// Used by bpm_emitter and bus_poll_master_core; depends on nothing else.
package bpm_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_BYTE   = 2'd1;
  localparam logic [1:0] OP_SWITCH = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_PONG = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_NCOUNT  = 2'd1;
  localparam logic [1:0] REG_NADDR   = 2'd2;
  localparam logic [1:0] REG_PONGEN  = 2'd3;

  // Command codes, in round-robin order.
  localparam logic [1:0] CMD_TEMP = 2'd0;
  localparam logic [1:0] CMD_PIR  = 2'd1;
  localparam logic [1:0] CMD_ALL  = 2'd2;
  localparam logic [1:0] CMD_PING = 2'd3;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [31:0] TXT_TEMP = "TEMP";
  localparam logic [31:0] TXT_PIR  = {"PIR", 8'h00};
  localparam logic [31:0] TXT_ALL  = {"ALL", 8'h00};
  localparam logic [31:0] TXT_PING = "PING";
  localparam logic [31:0] TXT_PONG = "PONG";

  localparam logic [3:0] MAX_RESULTS = 4'd9;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [7:0]  rx_byte;
    logic        ping_on;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       pong_ok;
    logic [7:0] line_addr;
    logic       last;
  } result_t;

  // Description of all results one item causes: an optional pong failure
  // first, then at most a request frame or one status result.
  typedef struct packed {
    logic       fail_pre;
    logic       frame;
    logic [7:0] addr;
    logic [1:0] cmd;
    logic       single;
    logic [1:0] s_kind;
    logic       s_ok;
    logic [7:0] s_addr;
  } bpm_seq_t;

  // Picks character i (0 is the first) from a four-character word.
  function automatic logic [7:0] text_char(logic [31:0] word, logic [1:0] i);
    logic [31:0] w;
    w = word >> {(2'd3 - i), 3'b000};
    return w[7:0];
  endfunction

  function automatic logic [3:0] cmd_len(logic [1:0] cmd);
    return ((cmd == CMD_TEMP) || (cmd == CMD_PING)) ? 4'd4 : 4'd3;
  endfunction

  function automatic logic [31:0] cmd_word(logic [1:0] cmd);
    logic [31:0] w;
    unique case (cmd)
      CMD_TEMP: w = TXT_TEMP;
      CMD_PIR:  w = TXT_PIR;
      CMD_ALL:  w = TXT_ALL;
      default:  w = TXT_PING;
    endcase
    return w;
  endfunction

  // Byte p of a request frame: addr, addr, command letters, CR, LF.
  function automatic logic [7:0] frame_byte(logic [7:0] addr, logic [1:0] cmd,
                                            logic [3:0] p);
    logic [3:0] len;
    logic [3:0] ci;
    logic [7:0] b;
    len = cmd_len(cmd);
    ci  = p - 4'd2;
    if (p < 4'd2) begin
      b = addr;
    end else if (p < len + 4'd2) begin
      b = text_char(cmd_word(cmd), ci[1:0]);
    end else if (p == len + 4'd2) begin
      b = CHAR_CR;
    end else begin
      b = CHAR_LF;
    end
    return b;
  endfunction

  function automatic logic [7:0] node_byte(logic [63:0] addrs, logic [2:0] i);
    logic [63:0] w;
    w = addrs >> {i, 3'b000};
    return w[7:0];
  endfunction

endpackage

[src/bpm_emitter.sv]
// Result sequencer and output register of the bus poll master.
// Expands one result description into result transactions; uses bpm_pkg.
module bpm_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  bpm_pkg::bpm_seq_t   seq_in,
  output logic                free,
  output logic                result_valid,
  input  logic                result_ready,
  output bpm_pkg::result_t    result
);

  bpm_pkg::bpm_seq_t seq;
  logic [3:0]        rem;
  logic [3:0]        pos;
  logic [3:0]        count_in;
  logic [3:0]        p;
  logic              emit;
  bpm_pkg::result_t  cur;

  assign count_in = 4'(seq_in.fail_pre) + 4'(seq_in.single) +
                    (seq_in.frame ? bpm_pkg::cmd_len(seq_in.cmd) + 4'd4 : 4'd0);

  assign emit = (rem != 4'd0) && (!result_valid || result_ready);
  assign free = (rem == 4'd0) || ((rem == 4'd1) && emit);

  always_comb begin
    p   = pos - 4'(seq.fail_pre);
    cur = '0;
    if (seq.fail_pre && (pos == 4'd0)) begin
      cur.kind = bpm_pkg::KIND_PONG;
    end else if (seq.frame) begin
      cur.kind    = bpm_pkg::KIND_TX;
      cur.tx_byte = bpm_pkg::frame_byte(seq.addr, seq.cmd, p);
    end else begin
      cur.kind      = seq.s_kind;
      cur.pong_ok   = seq.s_ok;
      cur.line_addr = seq.s_addr;
    end
    cur.last = (rem == 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem          <= 4'd0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (load) begin
        rem <= count_in;
      end else if (emit) begin
        rem <= rem - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= cur;
    end
    if (load) begin
      seq <= seq_in;
      pos <= 4'd0;
    end else if (emit) begin
      pos <= pos + 4'd1;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst) load |-> free)
    else $error("sequence loaded while results are still pending");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= bpm_pkg::MAX_RESULTS)
    else $error("pending result count out of range");

  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    load |=> (rem != 4'd0))
    else $error("loaded sequence holds no result");

endmodule

[src/bus_poll_master_core.sv]
// Top level of the bus poll master: configuration registers, poll state and
// line receiver. Uses bpm_pkg and bpm_emitter.
//
// Usage. Input transactions on item/item_valid/item_ready carry one event:
// a poll tick with the millisecond time, one received bus byte, or a change
// of the ping switch. Results leave on result/result_valid/result_ready, one
// per transaction: frame bytes to transmit, pong status updates and
// notices that a non-pong response line ended. The last flag marks the final
// result of an item. Configuration goes through the APB-style port, with
// registers at byte addresses 0, 8, 16 and 24 and 64-bit data; pready is
// always high. The user must write registers only while the block is idle;
// the block does not enforce this. An item is decoded and the poll state
// updated in its accept cycle; its first result goes via the sequencer into
// the result register. The sequencer hands out one result per cycle while
// the receiver takes them, so an item holds the input until its last result
// is out (a tick with a pong failure and a four-letter command has nine); an
// item with no result leaves the input ready. A new item is taken in the
// same cycle the previous item's last result enters the result register.
// Reset restores the register defaults and the idle poll state. When the
// receiver stalls, the result register holds and the input stalls behind it.
module bus_poll_master_core #(
  parameter int MAX_LINE  = 64,
  parameter int MAX_NODES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  bpm_pkg::item_t     item,
  output logic               result_valid,
  input  logic               result_ready,
  output bpm_pkg::result_t   result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int NIW = $clog2(MAX_NODES + 1);
  localparam int LLW = $clog2(MAX_LINE + 1);

  // Configuration registers.
  logic [15:0] reply_timeout;
  logic [3:0]  node_count;
  logic [63:0] node_addresses;
  logic        pong_report_enable;

  // Poll and receive state.
  logic           awaiting_reply, awaiting_reply_next;
  logic           awaiting_pong, awaiting_pong_next;
  logic           ping_due, ping_due_next;
  logic           ping_enabled, ping_enabled_next;
  logic [NIW-1:0] node_index, node_index_next;
  logic [1:0]     command_index, command_index_next;
  logic [7:0]     active_address, active_address_next;
  logic [31:0]    request_time, request_time_next;
  logic [LLW-1:0] line_length, line_length_next;
  logic           pong_match, pong_match_next;

  logic              accept;
  logic              cfg_write;
  logic              load;
  bpm_pkg::bpm_seq_t seq;

  // Tick helpers.
  logic [3:0]     n_eff;
  logic [NIW-1:0] ni;
  logic [7:0]     poll_addr;
  logic [31:0]    elapsed;
  logic           timed_out;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign accept    = item_valid && item_ready;

  // Configuration write and read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_timeout      <= 16'd100;
      node_count         <= 4'd0;
      node_addresses     <= 64'd0;
      pong_report_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        bpm_pkg::REG_TIMEOUT: reply_timeout      <= pwdata[15:0];
        bpm_pkg::REG_NCOUNT:  node_count         <= pwdata[3:0];
        bpm_pkg::REG_NADDR:   node_addresses     <= pwdata;
        default:              pong_report_enable <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      bpm_pkg::REG_TIMEOUT: prdata = {48'd0, reply_timeout};
      bpm_pkg::REG_NCOUNT:  prdata = {60'd0, node_count};
      bpm_pkg::REG_NADDR:   prdata = node_addresses;
      default:              prdata = {63'd0, pong_report_enable};
    endcase
  end

  // The node list never runs past MAX_NODES entries; an index that has
  // fallen off the end of a shortened list wraps to the first node.
  assign n_eff     = (node_count > 4'(MAX_NODES)) ? 4'(MAX_NODES) : node_count;
  assign ni        = (4'(node_index) >= n_eff) ? '0 : node_index;
  assign poll_addr = bpm_pkg::node_byte(node_addresses, 3'(ni));
  assign elapsed   = item.now_ms - request_time;
  assign timed_out = elapsed >= {16'd0, reply_timeout};

  always_comb begin
    awaiting_reply_next = awaiting_reply;
    awaiting_pong_next  = awaiting_pong;
    ping_due_next       = ping_due;
    ping_enabled_next   = ping_enabled;
    node_index_next     = node_index;
    command_index_next  = command_index;
    active_address_next = active_address;
    request_time_next   = request_time;
    line_length_next    = line_length;
    pong_match_next     = pong_match;
    seq                 = '0;

    unique case (item.op)
      bpm_pkg::OP_TICK: begin
        // A tick inside the reply window does nothing at all.
        if (!awaiting_reply || timed_out) begin
          if (awaiting_reply) begin
            seq.fail_pre        = awaiting_pong && pong_report_enable;
            awaiting_pong_next  = 1'b0;
            awaiting_reply_next = 1'b0;
          end
          if (ping_enabled && ping_due) begin
            // With an empty node list the ping goes to address zero.
            seq.frame           = 1'b1;
            seq.cmd             = bpm_pkg::CMD_PING;
            seq.addr            = (n_eff != 4'd0) ? poll_addr : 8'd0;
            if (n_eff != 4'd0) begin
              node_index_next = ni;
            end
            active_address_next = seq.addr;
            request_time_next   = item.now_ms;
            awaiting_reply_next = 1'b1;
            awaiting_pong_next  = 1'b1;
            ping_due_next       = 1'b0;
          end else if (n_eff == 4'd0) begin
            ping_due_next = ping_enabled;
          end else begin
            seq.frame           = 1'b1;
            seq.cmd             = command_index;
            seq.addr            = poll_addr;
            active_address_next = poll_addr;
            request_time_next   = item.now_ms;
            awaiting_reply_next = 1'b1;
            ping_due_next       = ping_enabled;
            command_index_next  = command_index + 2'd1;
            // After the last command of a node, move on to the next node.
            node_index_next = (command_index == bpm_pkg::CMD_PING) ? ni + NIW'(1) : ni;
          end
        end
      end
      bpm_pkg::OP_BYTE: begin
        if (item.rx_byte == bpm_pkg::CHAR_CR) begin
          // Carriage returns are skipped.
        end else if (item.rx_byte == bpm_pkg::CHAR_LF) begin
          if (line_length != '0) begin
            awaiting_reply_next = 1'b0;
            seq.s_addr          = active_address;
            if ((line_length == LLW'(4)) && pong_match) begin
              awaiting_pong_next = 1'b0;
              seq.single         = pong_report_enable;
              seq.s_kind         = bpm_pkg::KIND_PONG;
              seq.s_ok           = 1'b1;
            end else begin
              seq.single = 1'b1;
              seq.s_kind = bpm_pkg::KIND_LINE;
            end
          end
          line_length_next = '0;
          pong_match_next  = 1'b1;
        end else if (line_length >= LLW'(MAX_LINE)) begin
          // An over-long line is dropped along with the byte that overflowed it.
          line_length_next = '0;
          pong_match_next  = 1'b1;
        end else begin
          if ((line_length >= LLW'(4)) ||
              (item.rx_byte != bpm_pkg::text_char(bpm_pkg::TXT_PONG, line_length[1:0]))) begin
            pong_match_next = 1'b0;
          end
          line_length_next = line_length + LLW'(1);
        end
      end
      bpm_pkg::OP_SWITCH: begin
        ping_enabled_next = item.ping_on;
        if (!item.ping_on) begin
          // Switching pings off cancels any ping wait and, when pong reports are enabled, always reports failure.
          if (awaiting_pong) begin
            awaiting_reply_next = 1'b0;
          end
          awaiting_pong_next = 1'b0;
          seq.single         = pong_report_enable;
          seq.s_kind         = bpm_pkg::KIND_PONG;
        end
      end
      default: begin
      end
    endcase
  end

  assign load = accept && (seq.fail_pre || seq.frame || seq.single);

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_reply <= 1'b0;
      awaiting_pong  <= 1'b0;
      ping_due       <= 1'b1;
      ping_enabled   <= 1'b1;
      node_index     <= '0;
      command_index  <= 2'd0;
      active_address <= 8'd0;
      request_time   <= 32'd0;
      line_length    <= '0;
      pong_match     <= 1'b1;
    end else if (accept) begin
      awaiting_reply <= awaiting_reply_next;
      awaiting_pong  <= awaiting_pong_next;
      ping_due       <= ping_due_next;
      ping_enabled   <= ping_enabled_next;
      node_index     <= node_index_next;
      command_index  <= command_index_next;
      active_address <= active_address_next;
      request_time   <= request_time_next;
      line_length    <= line_length_next;
      pong_match     <= pong_match_next;
    end
  end

  bpm_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .seq_in       (seq),
    .free         (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
